@@ hw/rtl/rec_pkg.sv @@
// package for the carryless range encoder: payload and command types, constants
// used by rec_front, rec_queue, rec_back and range_encoder_core
package rec_pkg;

   // count width of the frequency model fields
   localparam int FREQ_BITS = 16;
   localparam int LOW_BITS = 64;
   localparam int BYTE_BITS = 8;
   localparam int MAX_BYTES = 8;
   localparam int TOP_SHIFT = 56;
   localparam int QUEUE_DEPTH = 2;

   // configuration register indexes
   localparam logic CSR_TOP_THRESHOLD = 1'b0;
   localparam logic CSR_BOTTOM_THRESHOLD = 1'b1;

   localparam logic [LOW_BITS-1:0] TOP_RESET = 64'h0100_0000_0000_0000;
   localparam logic [LOW_BITS-1:0] BOTTOM_RESET = 64'h0001_0000_0000_0000;
   localparam logic [LOW_BITS-1:0] ALL_ONES = '1;

   // input item mode codes
   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_FLUSH = 1'b1;

   typedef struct packed {
      logic                 mode;
      logic [FREQ_BITS-1:0] cumulative_count;
      logic [FREQ_BITS-1:0] symbol_count;
      logic [FREQ_BITS-1:0] total_count;
   } req_payload_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0] out_byte;
      logic                 last_byte;
   } rsp_payload_type;

   // classified command handed from front to back
   typedef struct packed {
      logic                 flush;
      logic [FREQ_BITS-1:0] cum;
      logic [FREQ_BITS-1:0] freq;
      logic [FREQ_BITS-1:0] total;
   } cmd_type;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ hw/rtl/rec_front.sv @@
// front stage: accepts request transfers and classifies them into commands
// depends on rec_pkg
module rec_front
   import rec_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_payload_type  req_payload,
   input  queue_status_type q_status,
   output logic             push,
   output cmd_type          push_cmd
);

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    take;

   // hold one item until the queue has room
   assign push = valid_ff && !q_status.full;
   assign req_stall = valid_ff && q_status.full;
   assign take = req_valid && !req_stall;
   assign push_cmd = cmd_ff;

   always_comb begin
      valid_in = take || (valid_ff && !push);
      cmd_in = cmd_ff;
      if (take) begin
         cmd_in.flush = (req_payload.mode == MODE_FLUSH);
         cmd_in.cum = req_payload.cumulative_count;
         cmd_in.freq = req_payload.symbol_count;
         cmd_in.total = req_payload.total_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule

@@ hw/rtl/rec_queue.sv @@
// short command queue between front and back stages
// depends on rec_pkg
module rec_queue
   import rec_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_cmd,
   input  logic             pop,
   output cmd_type          pop_cmd,
   output queue_status_type q_status
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   cmd_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]     count_ff;

   assign q_status.full = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign pop_cmd = slot_ff[rd_ptr_ff];

   // pointers wrap at the depth
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ hw/rtl/rec_back.sv @@
// back stage: divider, interval update, normalization, flush and response register
// depends on rec_pkg
module rec_back
   import rec_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic                csr_index,
   input  logic [LOW_BITS-1:0] csr_write_data,
   input  queue_status_type    q_status,
   input  cmd_type             pop_cmd,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_payload_type     rsp_payload
);

   localparam int DIV_CNT_W = $clog2(LOW_BITS);
   localparam int N_W = $clog2(MAX_BYTES) + 1;
   localparam int F_CNT_W = $clog2(MAX_BYTES);

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV, ST_MUL_CUM, ST_MUL_FREQ, ST_SET_RANGE, ST_NORM, ST_FLUSH
   } state_type;

   state_type             state_ff;
   logic [LOW_BITS-1:0]   top_ff, bottom_ff;
   logic [LOW_BITS-1:0]   low_ff, range_ff;
   logic [LOW_BITS-1:0]   quo_ff, prod_ff;
   logic [FREQ_BITS-1:0]  rem_ff;
   logic [DIV_CNT_W-1:0]  div_cnt_ff;
   cmd_type               cmd_ff;
   logic [N_W-1:0]        n_ff;
   logic [F_CNT_W-1:0]    f_cnt_ff;
   logic                  pend_valid_ff;
   logic [BYTE_BITS-1:0]  pend_byte_ff;
   logic                  rsp_valid_ff;
   rsp_payload_type       rsp_payload_ff;

   logic [FREQ_BITS:0]    trial;
   logic                  trial_ge;
   logic [LOW_BITS:0]     sum;
   logic [LOW_BITS-1:0]   xor_val;
   logic                  stop;
   logic                  slot_free;
   logic                  emit;

   assign pop = (state_ff == ST_IDLE) && !q_status.empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // a byte moves into the response register this cycle
   assign emit = slot_free && (((state_ff == ST_NORM) && pend_valid_ff)
                               || (state_ff == ST_FLUSH));

   // one restoring division step per cycle
   assign trial = {rem_ff, quo_ff[LOW_BITS-1]};
   assign trial_ge = (trial >= {1'b0, cmd_ff.total});

   // stop test: carry out counts as passing the xor compare
   assign sum = {1'b0, low_ff} + {1'b0, range_ff};
   assign xor_val = sum[LOW_BITS] ? ALL_ONES : (low_ff ^ sum[LOW_BITS-1:0]);
   assign stop = ((xor_val >= top_ff) && (range_ff >= bottom_ff))
                 || (n_ff == N_W'(MAX_BYTES));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         top_ff <= TOP_RESET;
         bottom_ff <= BOTTOM_RESET;
         low_ff <= '0;
         range_ff <= ALL_ONES;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // configuration writes
         if (csr_write_enable) begin
            case (csr_index)
               CSR_TOP_THRESHOLD: top_ff <= csr_write_data;
               CSR_BOTTOM_THRESHOLD: bottom_ff <= csr_write_data;
               default: ;
            endcase
         end
         // response register valid
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (!q_status.empty) begin
                  cmd_ff <= pop_cmd;
                  quo_ff <= range_ff;
                  rem_ff <= '0;
                  div_cnt_ff <= '0;
                  n_ff <= '0;
                  f_cnt_ff <= '0;
                  state_ff <= pop_cmd.flush ? ST_FLUSH : ST_DIV;
               end
            end
            ST_DIV: begin
               rem_ff <= trial_ge ? FREQ_BITS'(trial - {1'b0, cmd_ff.total})
                                  : trial[FREQ_BITS-1:0];
               quo_ff <= {quo_ff[LOW_BITS-2:0], trial_ge};
               div_cnt_ff <= div_cnt_ff + 1'b1;
               if (div_cnt_ff == DIV_CNT_W'(LOW_BITS - 1)) begin
                  state_ff <= ST_MUL_CUM;
               end
            end
            ST_MUL_CUM: begin
               prod_ff <= LOW_BITS'(quo_ff * {{(LOW_BITS-FREQ_BITS){1'b0}}, cmd_ff.cum});
               state_ff <= ST_MUL_FREQ;
            end
            ST_MUL_FREQ: begin
               low_ff <= low_ff + prod_ff;
               prod_ff <= LOW_BITS'(quo_ff * {{(LOW_BITS-FREQ_BITS){1'b0}}, cmd_ff.freq});
               state_ff <= ST_SET_RANGE;
            end
            ST_SET_RANGE: begin
               range_ff <= (prod_ff == '0) ? LOW_BITS'(1) : prod_ff;
               state_ff <= ST_NORM;
            end
            ST_NORM: begin
               // a byte waits in the pending slot until we know if it is the last
               if (stop) begin
                  if (!pend_valid_ff) begin
                     state_ff <= ST_IDLE;
                  end else if (slot_free) begin
                     rsp_payload_ff.out_byte <= pend_byte_ff;
                     rsp_payload_ff.last_byte <= 1'b1;
                     pend_valid_ff <= 1'b0;
                     state_ff <= ST_IDLE;
                  end
               end else if (!pend_valid_ff || slot_free) begin
                  if (pend_valid_ff) begin
                     rsp_payload_ff.out_byte <= pend_byte_ff;
                     rsp_payload_ff.last_byte <= 1'b0;
                  end
                  pend_valid_ff <= 1'b1;
                  pend_byte_ff <= low_ff[LOW_BITS-1 -: BYTE_BITS];
                  low_ff <= low_ff << BYTE_BITS;
                  range_ff <= range_ff << BYTE_BITS;
                  n_ff <= n_ff + 1'b1;
               end
            end
            ST_FLUSH: begin
               if (slot_free) begin
                  rsp_payload_ff.out_byte <= low_ff[TOP_SHIFT +: BYTE_BITS];
                  rsp_payload_ff.last_byte <= (f_cnt_ff == F_CNT_W'(MAX_BYTES - 1));
                  low_ff <= low_ff << BYTE_BITS;
                  f_cnt_ff <= f_cnt_ff + 1'b1;
                  if (f_cnt_ff == F_CNT_W'(MAX_BYTES - 1)) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

@@ hw/rtl/range_encoder_core.sv @@
// top level of the carryless 64-bit range encoder
// depends on rec_pkg, rec_front, rec_queue, rec_back
//
// Usage: each request transfer carries mode, cumulative, symbol and total
// counts. An encode request yields 0 to 8 response transfers (coded bytes);
// a flush request yields exactly 8 bytes and clears low. last_byte marks
// the final byte of each request. Requests with no bytes give no response.
// In the back stage an encode request loads the command, runs the bit-serial
// range / total divider, forms the two products, updates the interval and
// then normalizes, handing out bytes; a flush shifts out the bytes of low.
// The back stage takes a new command only when it is done with the last.
// The front stage and a two-entry command queue take new requests while
// the back stage works.
// Reset (synchronous): low = 0, range = all ones, thresholds at defaults,
// queue and response register empty.
// Stalling rsp holds the response register; the back stage waits on it
// and the front stalls requests once the queue fills.
// Thresholds are to be written through csr_* only while the block is idle; the block does not enforce this.
module range_encoder_core
   import rec_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_payload_type     req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_payload_type     rsp_payload,
   input  logic                csr_write_enable,
   input  logic                csr_index,
   input  logic [LOW_BITS-1:0] csr_write_data
);

   queue_status_type q_status;
   logic             push, pop;
   cmd_type          push_cmd, pop_cmd;

   rec_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_status    (q_status),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   rec_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .q_status (q_status)
   );

   rec_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .q_status         (q_status),
      .pop_cmd          (pop_cmd),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload)
   );

   // queue never written when full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && q_status.full))
      else $error("command queue overflow");

   // queue never read when empty
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && q_status.empty))
      else $error("command queue underflow");

   // reset leaves no response pending
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("response or stall active after reset");

endmodule
